// File: rtl/core/rc4_pkg.sv
package rc4_pkg;

  // Fixed sizes of the cipher.
  localparam int BW          = 8;
  localparam int PERM_DEPTH  = 256;
  localparam int PERM_AW     = 8;
  localparam int KEY_DEPTH_DEF = 256;
  localparam int PC_W        = 4;

  // Read address selects for the permutation memory.
  localparam logic [1:0] RA_I     = 2'd0;
  localparam logic [1:0] RA_I_INC = 2'd1;
  localparam logic [1:0] RA_J_SUM = 2'd2;
  localparam logic [1:0] RA_T     = 2'd3;

  // Write selects: entry i gets the read data, or entry j gets the held value a.
  localparam logic WS_I = 1'b0;
  localparam logic WS_J = 1'b1;

  // Index register operations.
  localparam logic [1:0] IX_HOLD = 2'd0;
  localparam logic [1:0] IX_STEP = 2'd1;
  localparam logic [1:0] IX_CLR  = 2'd2;

  // Sequencer operations.
  localparam logic [2:0] SQ_NEXT = 3'd0;
  localparam logic [2:0] SQ_JMP  = 3'd1;
  localparam logic [2:0] SQ_IDLE = 3'd2;
  localparam logic [2:0] SQ_BR   = 3'd3;
  localparam logic [2:0] SQ_WAIT = 3'd4;

  // Branch conditions.
  localparam logic [1:0] C_NONE     = 2'd0;
  localparam logic [1:0] C_NOTLAST  = 2'd1;
  localparam logic [1:0] C_MORE     = 2'd2;
  localparam logic [1:0] C_OUT_BUSY = 2'd3;

  // Program addresses.
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_G0   = 4'd1;
  localparam logic [PC_W-1:0] PC_G1   = 4'd2;
  localparam logic [PC_W-1:0] PC_G2   = 4'd3;
  localparam logic [PC_W-1:0] PC_G3   = 4'd4;
  localparam logic [PC_W-1:0] PC_KS   = 4'd5;
  localparam logic [PC_W-1:0] PC_K0   = 4'd6;
  localparam logic [PC_W-1:0] PC_K1   = 4'd7;
  localparam logic [PC_W-1:0] PC_K2   = 4'd8;
  localparam logic [PC_W-1:0] PC_K3   = 4'd9;
  localparam logic [PC_W-1:0] PC_K4   = 4'd10;
  localparam logic [PC_W-1:0] PC_KE   = 4'd11;

  // One control word of the program.
  typedef struct packed {
    logic            rd_en;
    logic [1:0]      rd_sel;
    logic            wr_en;
    logic            wr_sel;
    logic [1:0]      i_op;
    logic [1:0]      j_op;
    logic            key_add;
    logic            a_ld;
    logic            b_ld;
    logic [1:0]      k_op;
    logic            vclr;
    logic            kst;
    logic            kcnt_clr;
    logic            emit;
    logic [2:0]      sq;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } ctl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic last;
    logic more;
    logic out_busy;
  } dp_stat_t;

  // Microcode store.
  function automatic ctl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '0;
    case (pc)
      PC_IDLE: begin
        c.sq = SQ_IDLE;
      end
      // Generator: i advances and S[i] is read.
      PC_G0: begin
        c.rd_en  = 1'b1;
        c.rd_sel = RA_I_INC;
        c.i_op   = IX_STEP;
      end
      // Generator: j += S[i], then S[j] is read.
      PC_G1: begin
        c.rd_en  = 1'b1;
        c.rd_sel = RA_J_SUM;
        c.j_op   = IX_STEP;
        c.a_ld   = 1'b1;
      end
      // Generator: S[i] takes S[j] and the keystream entry is read.
      PC_G2: begin
        c.rd_en  = 1'b1;
        c.rd_sel = RA_T;
        c.wr_en  = 1'b1;
        c.wr_sel = WS_I;
        c.b_ld   = 1'b1;
      end
      // Generator: S[j] takes old S[i]; the result leaves once the slot is free.
      PC_G3: begin
        c.wr_en  = 1'b1;
        c.wr_sel = WS_J;
        c.emit   = 1'b1;
        c.sq     = SQ_WAIT;
        c.cond   = C_OUT_BUSY;
        c.target = PC_IDLE;
      end
      // Key byte store; a last byte falls through into the schedule.
      PC_KS: begin
        c.kst    = 1'b1;
        c.sq     = SQ_BR;
        c.cond   = C_NOTLAST;
        c.target = PC_IDLE;
      end
      // Schedule start: identity permutation, indices cleared.
      PC_K0: begin
        c.vclr = 1'b1;
        c.i_op = IX_CLR;
        c.j_op = IX_CLR;
        c.k_op = IX_CLR;
      end
      PC_K1: begin
        c.rd_en  = 1'b1;
        c.rd_sel = RA_I;
      end
      PC_K2: begin
        c.rd_en   = 1'b1;
        c.rd_sel  = RA_J_SUM;
        c.j_op    = IX_STEP;
        c.key_add = 1'b1;
        c.a_ld    = 1'b1;
      end
      PC_K3: begin
        c.wr_en  = 1'b1;
        c.wr_sel = WS_I;
      end
      PC_K4: begin
        c.wr_en  = 1'b1;
        c.wr_sel = WS_J;
        c.i_op   = IX_STEP;
        c.k_op   = IX_STEP;
        c.sq     = SQ_BR;
        c.cond   = C_MORE;
        c.target = PC_K1;
      end
      PC_KE: begin
        c.i_op     = IX_CLR;
        c.j_op     = IX_CLR;
        c.kcnt_clr = 1'b1;
        c.sq       = SQ_JMP;
        c.target   = PC_IDLE;
      end
      default: begin
        c.sq     = SQ_JMP;
        c.target = PC_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/rc4_in_if.sv
interface rc4_in_if;
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [rc4_pkg::BW-1:0]    byte_value;
  logic                      key_last;

  modport source (output valid, output opcode, output byte_value, output key_last,
                  input ready);
  modport sink   (input valid, input opcode, input byte_value, input key_last,
                  output ready);
endinterface

// File: rtl/core/rc4_out_if.sv
interface rc4_out_if;
  logic                      valid;
  logic                      ready;
  logic [rc4_pkg::BW-1:0]    data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

// File: rtl/core/rc4_stream_cipher.sv
// Data byte: taken while idle, then steps G0 to G3; result registered in G3 once the output is
// free, and no new byte is taken before that. Key byte: stored if room is left. Last key byte:
// 256-round schedule of four steps each on the permutation memory (one write and one read port).
// Reset clears the indices and the key count and marks every permutation entry as
// identity through per-entry valid bits; no clearing pass, items are taken at once.
module rc4_stream_cipher #(
  parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rc4_in_if.sink    in_chan,
  rc4_out_if.source out_chan
);

  rc4_pkg::ctl_t     ctl;
  rc4_pkg::dp_stat_t stat;
  logic              in_ready;
  logic              in_accept;

  assign in_chan.ready = in_ready;
  assign in_accept     = in_chan.valid && in_ready;

  // Program sequencer.
  rc4_useq u_useq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_is_data (in_chan.opcode),
    .stat       (stat),
    .ctl        (ctl),
    .in_ready   (in_ready)
  );

  // Memories, indices and output register.
  rc4_dpath #(
    .KEY_DEPTH (KEY_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_accept (in_accept),
    .in_byte   (in_chan.byte_value),
    .in_last   (in_chan.key_last),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.data_out),
    .stat      (stat)
  );

endmodule

// File: rtl/core/rc4_useq.sv
module rc4_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_is_data,
  input  rc4_pkg::dp_stat_t stat,
  output rc4_pkg::ctl_t     ctl,
  output logic              in_ready
);

  logic [rc4_pkg::PC_W-1:0] pc_r;
  logic [rc4_pkg::PC_W-1:0] pc_nxt;
  logic                     cond_hit;

  // Fetch the control word of the current step.
  assign ctl      = rc4_pkg::ucode_rom(pc_r);
  assign in_ready = (ctl.sq == rc4_pkg::SQ_IDLE);

  // Condition select.
  always_comb begin
    case (ctl.cond)
      rc4_pkg::C_NOTLAST:  cond_hit = !stat.last;
      rc4_pkg::C_MORE:     cond_hit = stat.more;
      rc4_pkg::C_OUT_BUSY: cond_hit = stat.out_busy;
      default:             cond_hit = 1'b0;
    endcase
  end

  // Next step.
  always_comb begin
    case (ctl.sq)
      rc4_pkg::SQ_NEXT: pc_nxt = pc_r + 1'b1;
      rc4_pkg::SQ_JMP:  pc_nxt = ctl.target;
      rc4_pkg::SQ_IDLE: begin
        if (in_valid) begin
          pc_nxt = in_is_data ? rc4_pkg::PC_G0 : rc4_pkg::PC_KS;
        end else begin
          pc_nxt = pc_r;
        end
      end
      rc4_pkg::SQ_BR:   pc_nxt = cond_hit ? ctl.target : pc_r + 1'b1;
      rc4_pkg::SQ_WAIT: pc_nxt = cond_hit ? pc_r : ctl.target;
      default:          pc_nxt = rc4_pkg::PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= rc4_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: rtl/core/rc4_dpath.sv
module rc4_dpath #(
  parameter int KEY_DEPTH = rc4_pkg::KEY_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rc4_pkg::ctl_t          ctl,
  input  logic                   in_accept,
  input  logic [rc4_pkg::BW-1:0] in_byte,
  input  logic                   in_last,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [rc4_pkg::BW-1:0] out_data,
  output rc4_pkg::dp_stat_t      stat
);

  localparam int BW  = rc4_pkg::BW;
  localparam int AW  = rc4_pkg::PERM_AW;
  localparam int KIW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int CW  = $clog2(KEY_DEPTH + 1);

  // Permutation memory with one valid bit per entry; an invalid entry reads as its index.
  logic [BW-1:0] perm_mem [rc4_pkg::PERM_DEPTH];
  logic [rc4_pkg::PERM_DEPTH-1:0] perm_vld_r;
  logic [BW-1:0] perm_q_r;
  logic          perm_qv_r;
  logic [AW-1:0] perm_qa_r;
  logic [BW-1:0] rdata;

  // Key memory.
  logic [BW-1:0] key_mem [KEY_DEPTH];
  logic [BW-1:0] key_q_r;

  logic [AW-1:0]  i_r, i_nxt;
  logic [AW-1:0]  j_r, j_nxt;
  logic [KIW-1:0] k_r, k_nxt;
  logic [CW-1:0]  kcnt_r, kcnt_nxt;
  logic [CW-1:0]  key_len;
  logic [BW-1:0]  a_r, b_r;
  logic [BW-1:0]  d_r;
  logic           last_r;
  logic           hit_i_r, hit_j_r;
  logic [AW-1:0]  j_sum;
  logic [AW-1:0]  t_addr;
  logic [AW-1:0]  raddr;
  logic [AW-1:0]  waddr;
  logic [BW-1:0]  wdata;
  logic [BW-1:0]  ks;
  logic           out_busy;
  logic           out_load;
  logic           out_valid_r;
  logic [BW-1:0]  out_data_r;
  logic           key_wr;

  assign rdata   = perm_qv_r ? perm_q_r : perm_qa_r;
  assign j_sum   = j_r + rdata + (ctl.key_add ? key_q_r : {BW{1'b0}});
  assign t_addr  = a_r + rdata;
  assign key_len = (kcnt_r == '0) ? CW'(1) : kcnt_r;
  assign key_wr  = ctl.kst && (kcnt_r < CW'(KEY_DEPTH));

  // Address and data selection for the permutation memory.
  always_comb begin
    case (ctl.rd_sel)
      rc4_pkg::RA_I:     raddr = i_r;
      rc4_pkg::RA_I_INC: raddr = i_r + 1'b1;
      rc4_pkg::RA_J_SUM: raddr = j_sum;
      rc4_pkg::RA_T:     raddr = t_addr;
      default:           raddr = i_r;
    endcase
  end

  assign waddr = (ctl.wr_sel == rc4_pkg::WS_J) ? j_r : i_r;
  assign wdata = (ctl.wr_sel == rc4_pkg::WS_J) ? a_r : rdata;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      perm_mem[waddr] <= wdata;
    end
    if (ctl.rd_en) begin
      perm_q_r  <= perm_mem[raddr];
      perm_qa_r <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      perm_vld_r <= '0;
      perm_qv_r  <= 1'b0;
    end else begin
      if (ctl.vclr) begin
        perm_vld_r <= '0;
      end else if (ctl.wr_en) begin
        perm_vld_r[waddr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        perm_qv_r <= perm_vld_r[raddr] && !ctl.vclr;
      end
    end
  end

  // Key memory: stored at the fill count, read at the schedule's key index.
  always_ff @(posedge clk) begin
    if (key_wr) begin
      key_mem[kcnt_r[KIW-1:0]] <= d_r;
    end
    key_q_r <= key_mem[k_r];
  end

  // Index updates.
  always_comb begin
    case (ctl.i_op)
      rc4_pkg::IX_STEP: i_nxt = i_r + 1'b1;
      rc4_pkg::IX_CLR:  i_nxt = '0;
      default:          i_nxt = i_r;
    endcase
    case (ctl.j_op)
      rc4_pkg::IX_STEP: j_nxt = j_sum;
      rc4_pkg::IX_CLR:  j_nxt = '0;
      default:          j_nxt = j_r;
    endcase
    case (ctl.k_op)
      rc4_pkg::IX_STEP: k_nxt = (CW'(k_r) == key_len - 1'b1) ? '0 : k_r + 1'b1;
      rc4_pkg::IX_CLR:  k_nxt = '0;
      default:          k_nxt = k_r;
    endcase
    if (ctl.kcnt_clr) begin
      kcnt_nxt = '0;
    end else if (key_wr) begin
      kcnt_nxt = kcnt_r + 1'b1;
    end else begin
      kcnt_nxt = kcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r    <= '0;
      j_r    <= '0;
      k_r    <= '0;
      kcnt_r <= '0;
    end else begin
      i_r    <= i_nxt;
      j_r    <= j_nxt;
      k_r    <= k_nxt;
      kcnt_r <= kcnt_nxt;
    end
  end

  // Working values: accepted transaction payload, swap operands and keystream bypass flags.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      d_r    <= in_byte;
      last_r <= in_last;
    end
    if (ctl.a_ld) begin
      a_r <= rdata;
    end
    if (ctl.b_ld) begin
      b_r     <= rdata;
      hit_i_r <= (t_addr == i_r);
      hit_j_r <= (t_addr == j_r);
    end
  end

  // The keystream entry may be one of the two just swapped.
  assign ks = hit_j_r ? a_r : (hit_i_r ? b_r : rdata);

  // Output register.
  assign out_busy = out_valid_r && !out_ready;
  assign out_load = ctl.emit && !out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= d_r ^ ks;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.last     = last_r;
  assign stat.more     = (i_r != {AW{1'b1}});
  assign stat.out_busy = out_busy;

endmodule

// File: test/tb_rc4_stream_cipher.sv
module tb_rc4_stream_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  // Item kinds carried by the opcode field.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  localparam int KEY_CAP       = rc4_pkg::KEY_DEPTH_DEF;
  localparam int TARGET_ITEMS  = 1350;
  localparam int MAX_WAIT      = 17;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 1100;

  typedef logic [rc4_pkg::BW-1:0] byte_t;

  // One pending input transaction; hold_for_drain makes the sender wait for all results.
  typedef struct packed {
    logic  hold_for_drain;
    logic  opcode;
    byte_t value;
    logic  key_last;
  } cipher_item_t;

  logic clk;
  logic rst_n;

  rc4_in_if  in_chan();
  rc4_out_if out_chan();

  rc4_stream_cipher u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Cipher state as seen by the checker.
  byte_t perm_model [rc4_pkg::PERM_DEPTH];
  byte_t key_bytes  [KEY_CAP];
  int    key_len;
  byte_t idx_i;
  byte_t idx_j;

  cipher_item_t pending_items [$];
  byte_t        expected_bytes [$];
  cipher_item_t in_flight;
  int           queued_count;
  int           mismatch_count;
  int           send_wait;
  int           recv_wait;
  bit           send_steady;
  bit           recv_steady;
  bit           send_holding;
  bit           send_next_valid;
  int           idle_cycles;

  // Swaps two permutation entries.
  task automatic swap_perm(input byte_t a, input byte_t b);
    byte_t t;
    t = perm_model[a];
    perm_model[a] = perm_model[b];
    perm_model[b] = t;
  endtask

  // Rebuilds the permutation from the stored key and restarts the stream.
  task automatic run_key_schedule();
    int    len;
    byte_t j;
    len = (key_len == 0) ? 1 : key_len;
    j = '0;
    for (int r = 0; r < rc4_pkg::PERM_DEPTH; r++) perm_model[r] = byte_t'(r);
    for (int r = 0; r < rc4_pkg::PERM_DEPTH; r++) begin
      j = j + perm_model[r] + key_bytes[r % len];
      swap_perm(byte_t'(r), j);
    end
    idx_i = '0;
    idx_j = '0;
    key_len = 0;
  endtask

  // Applies one accepted transaction; data bytes queue the expected ciphertext.
  task automatic cipher_step(input cipher_item_t item);
    byte_t ks_idx;
    if (item.opcode == OP_KEY) begin
      if (key_len < KEY_CAP) begin
        key_bytes[key_len] = item.value;
        key_len++;
      end
      if (item.key_last) run_key_schedule();
    end else begin
      idx_i = idx_i + 1'b1;
      idx_j = idx_j + perm_model[idx_i];
      swap_perm(idx_i, idx_j);
      ks_idx = perm_model[idx_i] + perm_model[idx_j];
      expected_bytes.push_back(item.value ^ perm_model[ks_idx]);
    end
  endtask

  task automatic report_mismatch(input string what, input byte_t got, input byte_t want);
    mismatch_count++;
    $display("[%0t] mismatch: %s, got %02h expected %02h", $realtime, what, got, want);
  endtask

  task automatic push_item(input logic op, input byte_t value, input logic last,
                           input logic drain);
    cipher_item_t item;
    item.hold_for_drain = drain;
    item.opcode = op;
    item.value = value;
    item.key_last = last;
    pending_items.push_back(item);
    queued_count++;
  endtask

  // A complete key of the given length with random bytes, the final one marked last.
  task automatic push_key(input int len);
    for (int n = 0; n < len; n++)
      push_item(OP_KEY, byte_t'($urandom_range(0, 255)), n == len - 1, 1'b0);
  endtask

  task automatic push_data(input int count);
    for (int n = 0; n < count; n++)
      push_item(OP_DATA, byte_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Wait before the next transaction; steady stretches do not wait at all.
  function automatic int draw_wait(input bit steady);
    return steady ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Clock and the known values on every driven input from time zero.
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.opcode = OP_KEY;
    in_chan.byte_value = '0;
    in_chan.key_last = 1'b0;
    out_chan.ready = 1'b0;
    forever #2 clk = ~clk;
  end

  // Sender: presents the queued items and updates the prediction on each transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_wait = 0;
      send_steady = 1'b0;
    end else begin
      send_holding = in_chan.valid && !in_chan.ready;
      if (in_chan.valid && in_chan.ready) begin
        cipher_step(in_flight);
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        send_wait = draw_wait(send_steady);
      end
      send_next_valid = send_holding;
      if (!send_holding) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_items.size() > 0 &&
                     (!pending_items[0].hold_for_drain || expected_bytes.size() == 0)) begin
          in_flight = pending_items.pop_front();
          in_chan.opcode <= in_flight.opcode;
          in_chan.byte_value <= in_flight.value;
          in_chan.key_last <= in_flight.key_last;
          send_next_valid = 1'b1;
        end
      end
      in_chan.valid <= send_next_valid;
    end
  end

  // Receiver: stalls at random and checks each result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_wait = 0;
      recv_steady = 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("result with nothing pending", out_chan.data_out, '0);
        end else begin
          byte_t want;
          want = expected_bytes.pop_front();
          if (out_chan.data_out !== want)
            report_mismatch("data_out", out_chan.data_out, want);
        end
        if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
        recv_wait = draw_wait(recv_steady);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_chan.ready <= (recv_wait == 0);
    end
  end

  // Watchdog on stretches without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    bit long_exact_done;
    bit long_over_done;
    int pick;

    for (int n = 0; n < rc4_pkg::PERM_DEPTH; n++) perm_model[n] = byte_t'(n);
    key_len = 0;
    idx_i = '0;
    idx_j = '0;
    queued_count = 0;
    mismatch_count = 0;
    long_exact_done = 1'b0;
    long_over_done = 1'b0;

    // Data before any key runs on the identity permutation; key_last is ignored on data.
    push_item(OP_DATA, 8'h00, 1'b0, 1'b0);
    push_item(OP_DATA, 8'hFF, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h5A, 1'b1, 1'b0);
    // Single-byte all-zero key, then the stream restarts.
    push_item(OP_KEY, 8'h00, 1'b1, 1'b0);
    push_item(OP_DATA, 8'h00, 1'b0, 1'b0);
    push_item(OP_DATA, 8'hFF, 1'b0, 1'b0);
    // Three-byte key with extreme values.
    push_item(OP_KEY, 8'hFF, 1'b0, 1'b0);
    push_item(OP_KEY, 8'h01, 1'b0, 1'b0);
    push_item(OP_KEY, 8'h80, 1'b1, 1'b0);
    // Sender holds off until every result so far has come back.
    push_item(OP_DATA, 8'h01, 1'b0, 1'b1);
    push_item(OP_DATA, 8'hAA, 1'b1, 1'b0);
    push_item(OP_DATA, 8'h55, 1'b0, 1'b0);
    // Key loading interrupted by data: the stream carries on and the key keeps growing.
    push_item(OP_KEY, 8'h7F, 1'b0, 1'b0);
    push_item(OP_DATA, 8'hFE, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h80, 1'b0, 1'b0);
    push_item(OP_KEY, 8'hFE, 1'b1, 1'b0);
    push_item(OP_DATA, 8'h7F, 1'b0, 1'b0);
    push_item(OP_DATA, 8'h01, 1'b0, 1'b0);

    // Random part: mostly a key followed by a data burst, with noise and broken keys.
    while (queued_count < TARGET_ITEMS) begin
      if (!long_exact_done && queued_count > 300) begin
        // Key that fills the key memory exactly.
        push_key(KEY_CAP);
        push_data($urandom_range(4, 20));
        long_exact_done = 1'b1;
      end else if (!long_over_done && queued_count > 800) begin
        // Overflowing key: extra bytes are dropped, the last one still starts the schedule.
        push_key(KEY_CAP + 1 + $urandom_range(0, 4));
        push_data($urandom_range(4, 20));
        long_over_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        push_key(($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16));
        push_data($urandom_range(1, 40));
      end else if (pick < 80) begin
        push_data($urandom_range(1, 30));
      end else if (pick < 90) begin
        for (int n = $urandom_range(3, 8); n > 0; n--)
          push_item(1'($urandom_range(0, 1)), byte_t'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'b0);
      end else begin
        for (int n = $urandom_range(1, 5); n > 0; n--)
          push_item(OP_KEY, byte_t'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_item(OP_DATA, byte_t'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 4) == 0));
        push_data($urandom_range(0, 10));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_items.size() > 0 || in_chan.valid || expected_bytes.size() > 0);
    // A trailing key schedule produces nothing; give it time to finish.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
